>>> design/mbrs_pkg.sv
// Package for the monochrome bitmap row scaler.
// Holds shared widths, register indexes, state codes and parameter defaults.
// No dependencies.
package mbrs_pkg;

    // Fixed widths of the transaction fields
    localparam int ROW_BITS   = 64;
    localparam int INDEX_W    = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int PAD_W      = $clog2(ROW_BITS);

    // Parameter defaults
    localparam int DEF_MAX_ROW_PIXELS = 64;
    localparam int DEF_MAX_ROWS       = 64;

    // Size register reset value
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_HEIGHT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HSCAN = 4'b0010,
        ST_HPAD  = 4'b0100,
        ST_VERT  = 4'b1000
    } state_t;

endpackage

>>> design/mono_bitmap_row_scaler_unit.sv
// An input transaction is scanned one horizontal DDA step per cycle, then the row is
// left-aligned one bit per cycle, then the vertical DDA takes one step per cycle while the
// output register is free, emitting at most one row per step.
// A new source row is taken only after the previous one has left the vertical stepper;
// output stalls hold the vertical stepper. Reset: rst_n is asynchronous; size registers
// return to MAX_ROW_PIXELS (widths) or 64 capped at MAX_ROWS (heights), vertical DDA to zero.
// Top level of the monochrome bitmap row scaler; uses mbrs_pkg.
module mono_bitmap_row_scaler_unit #(
    parameter int MAX_ROW_PIXELS = mbrs_pkg::DEF_MAX_ROW_PIXELS,
    parameter int MAX_ROWS       = mbrs_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              cfg_write,
    input  logic [mbrs_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [mbrs_pkg::CFG_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mbrs_pkg::ROW_BITS-1:0]     source_row,
    input  logic                              frame_start,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mbrs_pkg::ROW_BITS-1:0]     target_row,
    output logic [mbrs_pkg::INDEX_W-1:0]      target_index,
    output logic                              run_last
);

    localparam int HW = $clog2(MAX_ROW_PIXELS + 1);
    localparam int VW = $clog2(MAX_ROWS + 1);
    localparam int RB = mbrs_pkg::ROW_BITS;

    // Effective size registers (already clamped)
    logic [HW-1:0] sw_reg, sw_next;
    logic [HW-1:0] tw_reg, tw_next;
    logic [VW-1:0] sh_reg, sh_next;
    logic [VW-1:0] th_reg, th_next;

    // Sequencer and DDA state
    mbrs_pkg::state_t state_reg, state_next;
    logic [HW-1:0]    hse_reg, hse_next;
    logic [HW-1:0]    hde_reg, hde_next;
    logic [HW-1:0]    hstep_reg, hstep_next;
    logic [mbrs_pkg::PAD_W-1:0] pad_reg, pad_next;
    logic [VW-1:0]    vse_reg, vse_next;
    logic [VW-1:0]    vte_reg, vte_next;
    logic [VW-1:0]    tcnt_reg, tcnt_next;
    logic [VW-1:0]    scnt_reg, scnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload shift registers and output register
    logic [RB-1:0]    src_reg, src_next;
    logic [RB-1:0]    dst_reg, dst_next;
    logic [RB-1:0]    orow_reg, orow_next;
    logic [mbrs_pkg::INDEX_W-1:0] oidx_reg, oidx_next;
    logic             olast_reg, olast_next;

    // Datapath helpers
    logic             in_accept;
    logic             out_free;
    logic             drop;
    logic [HW-1:0]    hsteps;
    logic [HW:0]      hse_sum, hde_sum, hstep_inc;
    logic             sadv, dadv;
    logic [mbrs_pkg::PAD_W:0] pad_calc;
    logic [VW-1:0]    vsteps;
    logic [VW:0]      vse_sum, vte_sum, tcnt_inc;
    logic             vadv, vemit, tgt_end;
    logic [HW-1:0]    cfg_w_eff;
    logic [VW-1:0]    cfg_h_eff;

    assign in_stall     = (state_reg != mbrs_pkg::ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign target_row   = orow_reg;
    assign target_index = oidx_reg;
    assign run_last     = olast_reg;

    // Clamp of a written size: zero reads as one, oversize as the limit
    assign cfg_w_eff = (cfg_data == '0) ? HW'(1) :
                       (cfg_data > mbrs_pkg::CFG_W'(MAX_ROW_PIXELS)) ? HW'(MAX_ROW_PIXELS) :
                       HW'(cfg_data);
    assign cfg_h_eff = (cfg_data == '0) ? VW'(1) :
                       (cfg_data > mbrs_pkg::CFG_W'(MAX_ROWS)) ? VW'(MAX_ROWS) :
                       VW'(cfg_data);

    // Horizontal DDA step
    assign hsteps    = (sw_reg >= tw_reg) ? sw_reg : tw_reg;
    assign hse_sum   = {1'b0, hse_reg} + {1'b0, sw_reg};
    assign hde_sum   = {1'b0, hde_reg} + {1'b0, tw_reg};
    assign sadv      = (hse_sum >= {1'b0, hsteps});
    assign dadv      = (hde_sum >= {1'b0, hsteps});
    assign hstep_inc = {1'b0, hstep_reg} + (HW+1)'(1);
    assign pad_calc  = (mbrs_pkg::PAD_W+1)'(RB) - (mbrs_pkg::PAD_W+1)'(tw_reg);

    // Vertical DDA step
    assign vsteps   = (sh_reg >= th_reg) ? sh_reg : th_reg;
    assign vse_sum  = {1'b0, vse_reg} + {1'b0, sh_reg};
    assign vte_sum  = {1'b0, vte_reg} + {1'b0, th_reg};
    assign vadv     = (vse_sum >= {1'b0, vsteps});
    assign vemit    = (vte_sum >= {1'b0, vsteps});
    assign tcnt_inc = {1'b0, tcnt_reg} + (VW+1)'(1);
    assign tgt_end  = (tcnt_inc >= {1'b0, th_reg});

    // Row is dropped when the frame is already exhausted on either axis
    assign drop = !frame_start && ((scnt_reg >= sh_reg) || (tcnt_reg >= th_reg));

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        sw_next        = sw_reg;
        tw_next        = tw_reg;
        sh_next        = sh_reg;
        th_next        = th_reg;
        hse_next       = hse_reg;
        hde_next       = hde_reg;
        hstep_next     = hstep_reg;
        pad_next       = pad_reg;
        vse_next       = vse_reg;
        vte_next       = vte_reg;
        tcnt_next      = tcnt_reg;
        scnt_next      = scnt_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        orow_next      = orow_reg;
        oidx_next      = oidx_reg;
        olast_next     = olast_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            mbrs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    src_next   = source_row;
                    hse_next   = '0;
                    hde_next   = '0;
                    hstep_next = '0;
                    if (frame_start)
                    begin
                        vse_next  = '0;
                        vte_next  = '0;
                        tcnt_next = '0;
                        scnt_next = '0;
                    end
                    if (!drop)
                    begin
                        state_next = mbrs_pkg::ST_HSCAN;
                    end
                end
            end

            // one DDA step: shift a pixel in on the last step of each target pixel
            mbrs_pkg::ST_HSCAN:
            begin
                hse_next   = sadv ? HW'(hse_sum - {1'b0, hsteps}) : HW'(hse_sum);
                hde_next   = dadv ? HW'(hde_sum - {1'b0, hsteps}) : HW'(hde_sum);
                hstep_next = HW'(hstep_inc);
                if (sadv)
                begin
                    src_next = {src_reg[RB-2:0], 1'b0};
                end
                if (dadv)
                begin
                    dst_next = {dst_reg[RB-2:0], src_reg[RB-1]};
                end
                if (hstep_inc == {1'b0, hsteps})
                begin
                    pad_next   = pad_calc[mbrs_pkg::PAD_W-1:0];
                    state_next = (pad_calc == '0) ? mbrs_pkg::ST_VERT : mbrs_pkg::ST_HPAD;
                end
            end

            // left-align the row, filling unused pixels with zero
            mbrs_pkg::ST_HPAD:
            begin
                dst_next = {dst_reg[RB-2:0], 1'b0};
                pad_next = pad_reg - mbrs_pkg::PAD_W'(1);
                if (pad_reg == mbrs_pkg::PAD_W'(1))
                begin
                    state_next = mbrs_pkg::ST_VERT;
                end
            end

            // one vertical step per cycle while the output register is free
            mbrs_pkg::ST_VERT:
            begin
                if (out_free)
                begin
                    vse_next = vadv ? VW'(vse_sum - {1'b0, vsteps}) : VW'(vse_sum);
                    vte_next = vemit ? VW'(vte_sum - {1'b0, vsteps}) : VW'(vte_sum);
                    if (vadv)
                    begin
                        scnt_next = scnt_reg + VW'(1);
                    end
                    if (vemit)
                    begin
                        out_valid_next = 1'b1;
                        orow_next      = dst_reg;
                        oidx_next      = mbrs_pkg::INDEX_W'(tcnt_reg);
                        olast_next     = vadv || tgt_end;
                        tcnt_next      = VW'(tcnt_inc);
                    end
                    if (vadv || (vemit && tgt_end))
                    begin
                        state_next = mbrs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = mbrs_pkg::ST_IDLE;
            end
        endcase

        // configuration write restarts the vertical stepper
        if (cfg_write)
        begin
            unique case (cfg_index)
                mbrs_pkg::REG_SOURCE_WIDTH:  sw_next = cfg_w_eff;
                mbrs_pkg::REG_TARGET_WIDTH:  tw_next = cfg_w_eff;
                mbrs_pkg::REG_SOURCE_HEIGHT: sh_next = cfg_h_eff;
                mbrs_pkg::REG_TARGET_HEIGHT: th_next = cfg_h_eff;
                default: ;
            endcase
            vse_next  = '0;
            vte_next  = '0;
            tcnt_next = '0;
            scnt_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbrs_pkg::ST_IDLE;
            sw_reg        <= HW'(MAX_ROW_PIXELS);
            tw_reg        <= HW'(MAX_ROW_PIXELS);
            sh_reg        <= (mbrs_pkg::SIZE_RESET > mbrs_pkg::CFG_W'(MAX_ROWS)) ?
                             VW'(MAX_ROWS) : VW'(mbrs_pkg::SIZE_RESET);
            th_reg        <= (mbrs_pkg::SIZE_RESET > mbrs_pkg::CFG_W'(MAX_ROWS)) ?
                             VW'(MAX_ROWS) : VW'(mbrs_pkg::SIZE_RESET);
            hse_reg       <= '0;
            hde_reg       <= '0;
            hstep_reg     <= '0;
            pad_reg       <= '0;
            vse_reg       <= '0;
            vte_reg       <= '0;
            tcnt_reg      <= '0;
            scnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            tw_reg        <= tw_next;
            sh_reg        <= sh_next;
            th_reg        <= th_next;
            hse_reg       <= hse_next;
            hde_reg       <= hde_next;
            hstep_reg     <= hstep_next;
            pad_reg       <= pad_next;
            vse_reg       <= vse_next;
            vte_reg       <= vte_next;
            tcnt_reg      <= tcnt_next;
            scnt_reg      <= scnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        orow_reg  <= orow_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

endmodule

>>> design/mbrs_checker.sv
// Port-level checker for the monochrome bitmap row scaler, bound to the top level.
// Depends on mbrs_pkg for field widths.
module mbrs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [mbrs_pkg::ROW_BITS-1:0]     target_row,
    input logic [mbrs_pkg::INDEX_W-1:0]      target_index,
    input logic                              run_last
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target_row)
            && $stable(target_index) && $stable(run_last))
        else $error("stalled result transaction changed");

    // While a run is still open the input side must stay stalled
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> in_stall)
        else $error("input taken while a run of results is open");

    // A freshly accepted row cannot produce a result on the very next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared right after input transaction");

endmodule

bind mono_bitmap_row_scaler_unit mbrs_checker u_mbrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target_row   (target_row),
    .target_index (target_index),
    .run_last     (run_last)
);

>>> test/testbench.sv
// Self-checking testbench for mono_bitmap_row_scaler_unit.
// Holds a scoreboard class that predicts scaled rows, plus the tasks that drive the block.
// Depends on mbrs_pkg and the scaler RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 260;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int ROW_BUDGET    = 360;

    // one expected destination row
    typedef struct {
        logic [mbrs_pkg::ROW_BITS-1:0] row;
        logic [mbrs_pkg::INDEX_W-1:0]  index;
        logic                          last;
    } scaled_row_t;

    // Predicts the scaler and checks its results in order
    class row_scoreboard;
        logic [mbrs_pkg::CFG_W-1:0] size_reg [4];
        logic [mbrs_pkg::CFG_W-1:0] src_err, dst_err, dst_count, src_count;
        scaled_row_t                pending [$];
        int                         fail_count;
        int                         results_checked;

        function new();
            size_reg[mbrs_pkg::REG_SOURCE_WIDTH]  = mbrs_pkg::SIZE_RESET;
            size_reg[mbrs_pkg::REG_TARGET_WIDTH]  = mbrs_pkg::SIZE_RESET;
            size_reg[mbrs_pkg::REG_SOURCE_HEIGHT] = mbrs_pkg::SIZE_RESET;
            size_reg[mbrs_pkg::REG_TARGET_HEIGHT] = mbrs_pkg::SIZE_RESET;
            restart();
            fail_count      = 0;
            results_checked = 0;
        endfunction

        function void restart();
            src_err   = '0;
            dst_err   = '0;
            dst_count = '0;
            src_count = '0;
        endfunction

        // zero reads as one, oversize clamps to the maximum
        function logic [mbrs_pkg::CFG_W-1:0] eff_size(logic [mbrs_pkg::CFG_W-1:0] v,
                                                      int limit);
            if (v == 0)
                return mbrs_pkg::CFG_W'(1);
            if (v > limit)
                return mbrs_pkg::CFG_W'(limit);
            return v;
        endfunction

        function void write_reg(logic [mbrs_pkg::CFG_ADDR_W-1:0] idx,
                                logic [mbrs_pkg::CFG_W-1:0] val);
            size_reg[idx] = val;
            restart();
        endfunction

        // horizontal nearest-neighbor stepper, pixel 0 in the MSB
        function logic [mbrs_pkg::ROW_BITS-1:0] scale_pixels(
                logic [mbrs_pkg::ROW_BITS-1:0] src,
                logic [mbrs_pkg::CFG_W-1:0] sw,
                logic [mbrs_pkg::CFG_W-1:0] tw);
            logic [mbrs_pkg::CFG_W-1:0]    steps, sx, dx, se, de;
            logic [mbrs_pkg::ROW_BITS-1:0] dst;
            int                            t;
            steps = (sw >= tw) ? sw : tw;
            sx = '0;
            dx = '0;
            se = '0;
            de = '0;
            dst = '0;
            for (t = 0; t < steps; t++)
            begin
                if (sx < sw && dx < tw)
                    dst[63 - dx] = src[63 - sx];
                se = se + sw;
                if (se >= steps)
                begin
                    se = se - steps;
                    sx = sx + 1;
                end
                de = de + tw;
                if (de >= steps)
                begin
                    de = de - steps;
                    dx = dx + 1;
                end
            end
            return dst;
        endfunction

        // Notes an accepted source row; returns 1 if it fell inside the frame
        function bit note_row(logic [mbrs_pkg::ROW_BITS-1:0] src, logic fs);
            logic [mbrs_pkg::CFG_W-1:0]    sw, tw, sh, th, steps;
            logic [mbrs_pkg::ROW_BITS-1:0] scaled;
            scaled_row_t                   item;
            bit                            advanced;
            int                            n, g;
            sw = eff_size(size_reg[mbrs_pkg::REG_SOURCE_WIDTH], mbrs_pkg::DEF_MAX_ROW_PIXELS);
            tw = eff_size(size_reg[mbrs_pkg::REG_TARGET_WIDTH], mbrs_pkg::DEF_MAX_ROW_PIXELS);
            sh = eff_size(size_reg[mbrs_pkg::REG_SOURCE_HEIGHT], mbrs_pkg::DEF_MAX_ROWS);
            th = eff_size(size_reg[mbrs_pkg::REG_TARGET_HEIGHT], mbrs_pkg::DEF_MAX_ROWS);
            steps = (sh >= th) ? sh : th;
            advanced = 1'b0;
            n = 0;
            if (fs)
                restart();
            if (src_count >= sh || dst_count >= th)
                return 1'b0;
            scaled = scale_pixels(src, sw, tw);
            // vertical stepper: runs until the source row is consumed or the target frame is full
            for (g = 0; g < steps && !advanced; g++)
            begin
                if (dst_count >= th)
                    break;
                src_err = src_err + sh;
                if (src_err >= steps)
                begin
                    src_err   = src_err - steps;
                    src_count = src_count + 1;
                    advanced  = 1'b1;
                end
                dst_err = dst_err + th;
                if (dst_err >= steps)
                begin
                    dst_err    = dst_err - steps;
                    item.row   = scaled;
                    item.index = dst_count[mbrs_pkg::INDEX_W-1:0];
                    item.last  = 1'b0;
                    pending.push_back(item);
                    n++;
                    dst_count = dst_count + 1;
                end
            end
            // flag the end of this run
            if (n > 0)
            begin
                item = pending.pop_back();
                item.last = 1'b1;
                pending.push_back(item);
            end
            return 1'b1;
        endfunction

        // Compares one accepted result with the oldest expectation
        function void check_row(logic [mbrs_pkg::ROW_BITS-1:0] row,
                                logic [mbrs_pkg::INDEX_W-1:0] index,
                                logic last);
            scaled_row_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result row=%h index=%0d last=%b",
                         $time, row, index, last);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            results_checked++;
            if (row !== want.row)
            begin
                $display("%0t: target_row expected %h actual %h", $time, want.row, row);
                fail_count++;
            end
            if (index !== want.index)
            begin
                $display("%0t: target_index expected %0d actual %0d",
                         $time, want.index, index);
                fail_count++;
            end
            if (last !== want.last)
            begin
                $display("%0t: run_last expected %b actual %b", $time, want.last, last);
                fail_count++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [mbrs_pkg::CFG_ADDR_W-1:0] cfg_index;
    logic [mbrs_pkg::CFG_W-1:0]      cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [mbrs_pkg::ROW_BITS-1:0]   source_row;
    logic                            frame_start;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [mbrs_pkg::ROW_BITS-1:0]   target_row;
    logic [mbrs_pkg::INDEX_W-1:0]    target_index;
    logic                            run_last;

    row_scoreboard sb = new();
    int send_pct;
    int recv_pct;
    int rows_sent;
    int rows_in_frame;
    int settings_used;

    mono_bitmap_row_scaler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_row   (source_row),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_row   (target_row),
        .target_index (target_index),
        .run_last     (run_last)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check accepted transactions, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_row(target_row, target_index, run_last);
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    // idle modes: 0 none, 1 sender gaps, 2 receiver stalls, 3 light on both
    task set_idle_mode(input int mode);
        case (mode)
            1: begin send_pct = 52; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 52; end
            3: begin send_pct = 9;  recv_pct = 9;  end
            default: begin send_pct = 0; recv_pct = 0; end
        endcase
    endtask

    // One source row transaction, with optional leading gaps
    task send_source_row(input logic [mbrs_pkg::ROW_BITS-1:0] row, input logic fs);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        source_row  <= row;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rows_sent++;
        if (sb.note_row(row, fs))
            rows_in_frame++;
    endtask

    // Wait for every expected row, then let a row with no output finish
    task drain_and_settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending.size() > 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_register(input logic [mbrs_pkg::CFG_ADDR_W-1:0] idx,
                        input logic [mbrs_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task write_sizes(input logic [mbrs_pkg::CFG_W-1:0] sw, input logic [mbrs_pkg::CFG_W-1:0] tw,
                     input logic [mbrs_pkg::CFG_W-1:0] sh, input logic [mbrs_pkg::CFG_W-1:0] th);
        write_register(mbrs_pkg::REG_SOURCE_WIDTH, sw);
        write_register(mbrs_pkg::REG_TARGET_WIDTH, tw);
        write_register(mbrs_pkg::REG_SOURCE_HEIGHT, sh);
        write_register(mbrs_pkg::REG_TARGET_HEIGHT, th);
        settings_used++;
    endtask

    // mostly small sizes, some zero, oversize and full
    function logic [mbrs_pkg::CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 14)
            return mbrs_pkg::CFG_W'($urandom_range(65, 127));
        if (r < 24)
            return mbrs_pkg::CFG_W'(64);
        return mbrs_pkg::CFG_W'($urandom_range(1, 12));
    endfunction

    function logic [mbrs_pkg::ROW_BITS-1:0] random_row();
        return {$urandom, $urandom};
    endfunction

    // One frame: mostly well formed, sometimes cut short or with noise
    task run_frame();
        int sh, rows, r, i;
        logic fs;
        sh = sb.eff_size(sb.size_reg[mbrs_pkg::REG_SOURCE_HEIGHT], mbrs_pkg::DEF_MAX_ROWS);
        rows = sh;
        r = $urandom_range(0, 99);
        if (r < 10)
            rows = $urandom_range(1, sh);
        for (i = 0; i < rows && rows_sent < ROW_BUDGET; i++)
        begin
            fs = (i == 0) || ($urandom_range(0, 99) < 3);
            send_source_row(random_row(), fs);
        end
        // rows past the end of the frame
        if (r >= 88)
            repeat ($urandom_range(1, 3)) send_source_row(random_row(), 1'b0);
    endtask

    // Stimulus
    initial
    begin
        int setting;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        source_row  = '0;
        frame_start = 1'b0;
        send_pct    = 0;
        recv_pct    = 0;
        rows_sent     = 0;
        rows_in_frame = 0;
        settings_used = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: plain 64x64 copy
        set_idle_mode(0);
        send_source_row('1, 1'b1);
        send_source_row('0, 1'b0);
        send_source_row({32{2'b10}}, 1'b0);
        send_source_row({32{2'b01}}, 1'b0);
        drain_and_settle();

        // zero source sizes, oversize targets: one pixel to a full frame
        set_idle_mode(1);
        write_sizes(7'd0, 7'd127, 7'd0, 7'd127);
        send_source_row({1'b1, 63'd0}, 1'b1);
        send_source_row('1, 1'b0);                      // past the source frame
        send_source_row({1'b0, {63{1'b1}}}, 1'b1);
        drain_and_settle();

        // oversize source width, zero target width, 2 rows to 1
        set_idle_mode(2);
        write_sizes(7'd100, 7'd0, 7'd2, 7'd1);
        send_source_row(random_row(), 1'b1);
        send_source_row(random_row(), 1'b0);
        send_source_row(random_row(), 1'b0);
        drain_and_settle();

        // upscale, with a register write mid frame and a restart mid frame
        set_idle_mode(3);
        write_sizes(7'd5, 7'd13, 7'd3, 7'd7);
        send_source_row(random_row(), 1'b1);
        send_source_row(random_row(), 1'b0);
        drain_and_settle();
        write_register(mbrs_pkg::REG_TARGET_HEIGHT, 7'd7);
        send_source_row(random_row(), 1'b0);
        send_source_row(random_row(), 1'b0);
        send_source_row(random_row(), 1'b0);
        send_source_row(random_row(), 1'b0);
        send_source_row(random_row(), 1'b1);
        drain_and_settle();

        // downscale on both axes
        set_idle_mode(0);
        write_sizes(7'd13, 7'd5, 7'd7, 7'd3);
        send_source_row(random_row(), 1'b1);
        repeat (6) send_source_row(random_row(), 1'b0);
        drain_and_settle();

        // random sizes and frames, rotating the idle modes
        setting = 0;
        while (rows_sent < ROW_BUDGET)
        begin
            set_idle_mode(setting % 4);
            write_sizes(pick_size(), pick_size(), pick_size(), pick_size());
            repeat ($urandom_range(1, 3)) run_frame();
            drain_and_settle();
            setting++;
        end

        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d expected rows never arrived", $time, sb.pending.size());
            sb.fail_count++;
        end
        $display("Sent %0d source rows (%0d inside a frame) over %0d size settings,",
                 rows_sent, rows_in_frame, settings_used);
        $display("checked %0d scaled rows under four idle and stall patterns.",
                 sb.results_checked);
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/mbrs_pkg.sv
design/mono_bitmap_row_scaler_unit.sv
design/mbrs_checker.sv
test/testbench.sv
